// ===== design/pms_pkg.sv =====
// Shared types and constants for the permutation move scheduler.
// No dependencies.
package pms_pkg;

  localparam int SLOT_W = 10;
  localparam int CNT_W = 11;
  localparam int MAP_W = 11;
  localparam int DEPTH = 1 << SLOT_W;
  localparam logic [CNT_W-1:0] MAX_FRAG = CNT_W'(DEPTH);
  localparam logic [MAP_W-1:0] NO_HOLDER = '1;

  localparam logic [1:0] CFG_SOURCE_COUNT = 2'd0;
  localparam logic [1:0] CFG_TARGET_COUNT = 2'd1;
  localparam logic [1:0] CFG_REVERSE_MODE = 2'd2;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_START = 2'd1,
    FN_FETCH = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    K_COPY  = 3'd0,
    K_SWAP  = 3'd1,
    K_CLEAR = 3'd2,
    K_END   = 3'd3,
    K_ERROR = 3'd4
  } kind_t;

  typedef struct packed {
    logic [CNT_W-1:0] source_count;
    logic [CNT_W-1:0] target_count;
    logic             reverse_mode;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SLOT_W-1:0] first_slot;
    logic [SLOT_W-1:0] second_slot;
    logic              last;
  } res_t;

endpackage

// ===== design/pms_if.sv =====
// Valid/ready channel interfaces for the scheduler's input and output words.
// Depends on pms_pkg.
interface pms_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 func;
  logic [pms_pkg::SLOT_W-1:0] slot;
  logic signed [10:0]         source_slot;
  modport source (output valid, func, slot, source_slot, input ready);
  modport sink (input valid, func, slot, source_slot, output ready);
endinterface

interface pms_out_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 kind;
  logic [pms_pkg::SLOT_W-1:0] first_slot;
  logic [pms_pkg::SLOT_W-1:0] second_slot;
  logic                       last;
  modport source (output valid, kind, first_slot, second_slot, last, input ready);
  modport sink (input valid, kind, first_slot, second_slot, last, output ready);
endinterface

// ===== design/permutation_move_scheduler.sv =====
// Permutation move scheduler top level: config registers, engine and output register.
// Depends on pms_pkg, pms_if and pms_engine.
//
// Usage: write source_count, target_count and reverse_mode through the cfg port
// (index 0..2). Send load words (func 0) to fill the map, one start word (func 1),
// then fetch words (func 2); each fetch returns one command word on out_w, ending
// with an end or error word carrying last. Loads during a run are ignored; fetches
// when stopped give nothing.
// A load writes the map directly from idle. A start clears the settled and
// reader-count memories over all 1024 slots, then counts readers for each working slot.
// A fetch scans the slots of its phase through registered memory reads; a swap partner
// search probes the later slots one by one, and the first swap fetch also builds the
// holder table first.
// Reset returns the block to idle with no command pending. The map memory is
// not cleared. If the receiver stalls, a finished word waits in the output
// register and the engine holds its next word until the register frees.
module permutation_move_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  pms_in_if.sink                      in_w,
  pms_out_if.source                   out_w,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_addr,
  input  logic [pms_pkg::CNT_W-1:0]   cfg_wdata
);
  import pms_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid, res_ready, out_valid;
  res_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SOURCE_COUNT: cfg.source_count <= cfg_wdata;
        CFG_TARGET_COUNT: cfg.target_count <= cfg_wdata;
        CFG_REVERSE_MODE: cfg.reverse_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  pms_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_w.valid),
    .in_ready    (in_w.ready),
    .func        (in_w.func),
    .slot        (in_w.slot),
    .source_slot (in_w.source_slot),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !out_valid || out_w.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) out_res <= res;
  end

  assign out_w.valid       = out_valid;
  assign out_w.kind        = out_res.kind;
  assign out_w.first_slot  = out_res.first_slot;
  assign out_w.second_slot = out_res.second_slot;
  assign out_w.last        = out_res.last;

endmodule

// ===== design/pms_engine.sv =====
// Scheduling engine: map, settled, reader-count and holder memories plus the sequencer.
// Depends on pms_pkg.
module pms_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 func,
  input  logic [pms_pkg::SLOT_W-1:0] slot,
  input  logic [10:0]                source_slot,
  input  pms_pkg::cfg_t              cfg,
  output logic                       res_valid,
  input  logic                       res_ready,
  output pms_pkg::res_t              res
);
  import pms_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_CLR     = 16'h0002,
    S_CNT_RD  = 16'h0004,
    S_CNT_MAP = 16'h0008,
    S_CNT_INC = 16'h0010,
    S_DISP    = 16'h0020,
    S_EX_MAP  = 16'h0040,
    S_CP_CHK  = 16'h0080,
    S_CP_DEC  = 16'h0100,
    S_HI_RD   = 16'h0200,
    S_HI_WR   = 16'h0400,
    S_SW_CHK  = 16'h0800,
    S_SR_RD   = 16'h1000,
    S_SR_CHK  = 16'h2000,
    S_SW_W2   = 16'h4000,
    S_EMIT    = 16'h8000
  } state_t;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'h01,
    PH_EXTRA = 7'h02,
    PH_COPY  = 7'h04,
    PH_SWAP  = 7'h08,
    PH_END   = 7'h10,
    PH_DONE  = 7'h20,
    PH_ERROR = 7'h40
  } phase_t;

  logic [MAP_W-1:0] map_mem [DEPTH];
  logic             set_mem [DEPTH];
  logic [CNT_W-1:0] rc_mem  [DEPTH];
  logic [MAP_W-1:0] ho_mem  [DEPTH];

  logic [SLOT_W-1:0] map_ra, map_wa, st_ra, st_wa, rc_ra, rc_wa, ho_ra, ho_wa;
  logic              map_we, st_we, rc_we, ho_we, st_wd;
  logic [MAP_W-1:0]  map_wd, ho_wd, map_rd, ho_rd;
  logic [CNT_W-1:0]  rc_wd, rc_rd;
  logic              st_rd;

  state_t           st, st_next;
  phase_t           phase, phase_next;
  logic [CNT_W-1:0] scan, scan_next, total, total_next, rupd, rupd_next;
  logic [CNT_W-1:0] full, full_next, orig, orig_next, wc, wc_next, p, p_next;
  logic [MAP_W-1:0] m, m_next, hf, hf_next;
  logic [SLOT_W-1:0] cur, cur_next;
  res_t             res_next;
  logic [CNT_W-1:0] c_sel, o_sel, c_sat, o_sat;
  logic             loadable;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd <= map_mem[map_ra];
    if (st_we) set_mem[st_wa] <= st_wd;
    st_rd <= set_mem[st_ra];
    if (rc_we) rc_mem[rc_wa] <= rc_wd;
    rc_rd <= rc_mem[rc_ra];
    if (ho_we) ho_mem[ho_wa] <= ho_wd;
    ho_rd <= ho_mem[ho_ra];
  end

  assign in_ready  = (st == S_IDLE);
  assign res_valid = (st == S_EMIT);
  assign loadable  = (phase == PH_IDLE) || (phase == PH_DONE) || (phase == PH_ERROR);

  assign c_sel = cfg.reverse_mode ? cfg.source_count : cfg.target_count;
  assign o_sel = cfg.reverse_mode ? cfg.target_count : cfg.source_count;
  assign c_sat = (c_sel > MAX_FRAG) ? MAX_FRAG : c_sel;
  assign o_sat = (o_sel > MAX_FRAG) ? MAX_FRAG : o_sel;

  always_comb begin
    st_next = st;
    phase_next = phase;
    scan_next = scan;
    total_next = total;
    rupd_next = rupd;
    full_next = full;
    orig_next = orig;
    wc_next = wc;
    p_next = p;
    m_next = m;
    hf_next = hf;
    cur_next = cur;
    res_next = res;
    map_we = 1'b0; map_wa = slot; map_wd = source_slot; map_ra = scan[SLOT_W-1:0];
    st_we = 1'b0; st_wa = scan[SLOT_W-1:0]; st_wd = 1'b0; st_ra = scan[SLOT_W-1:0];
    rc_we = 1'b0; rc_wa = scan[SLOT_W-1:0]; rc_wd = '0; rc_ra = scan[SLOT_W-1:0];
    ho_we = 1'b0; ho_wa = scan[SLOT_W-1:0]; ho_wd = '0; ho_ra = scan[SLOT_W-1:0];
    case (st)
      S_IDLE: begin
        if (in_valid) begin
          case (func)
            FN_LOAD: begin
              map_we = loadable;
            end
            FN_START: begin
              full_next = c_sat;
              orig_next = o_sat;
              wc_next = (o_sat < c_sat) ? o_sat : c_sat;
              total_next = '0;
              rupd_next = '0;
              scan_next = '0;
              st_next = S_CLR;
            end
            FN_FETCH: begin
              if (!loadable) st_next = S_DISP;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        st_we = 1'b1;
        rc_we = 1'b1;
        if (scan == MAX_FRAG - 1'b1) begin
          scan_next = '0;
          st_next = S_CNT_RD;
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      S_CNT_RD: begin
        if (scan < wc) begin
          st_next = S_CNT_MAP;
        end else begin
          scan_next = orig;
          phase_next = PH_EXTRA;
          st_next = S_IDLE;
        end
      end
      S_CNT_MAP: begin
        m_next = map_rd;
        if (!map_rd[MAP_W-1] && map_rd == scan) begin
          st_we = 1'b1;
          st_wd = 1'b1;
          total_next = total + 1'b1;
          scan_next = scan + 1'b1;
          st_next = S_CNT_RD;
        end else if (!map_rd[MAP_W-1] && map_rd < wc) begin
          rc_ra = map_rd[SLOT_W-1:0];
          st_next = S_CNT_INC;
        end else begin
          scan_next = scan + 1'b1;
          st_next = S_CNT_RD;
        end
      end
      S_CNT_INC: begin
        rc_we = 1'b1;
        rc_wa = m[SLOT_W-1:0];
        rc_wd = rc_rd + 1'b1;
        scan_next = scan + 1'b1;
        st_next = S_CNT_RD;
      end
      S_DISP: begin
        case (phase)
          PH_EXTRA: begin
            if (scan < full) begin
              st_next = S_EX_MAP;
            end else begin
              scan_next = '0;
              rupd_next = '0;
              phase_next = (total < wc) ? PH_COPY : PH_END;
            end
          end
          PH_COPY: begin
            if (scan < wc) begin
              st_next = S_CP_CHK;
            end else begin
              scan_next = '0;
              if (rupd != '0 && total < wc) begin
                rupd_next = '0;
              end else if (total < wc) begin
                st_next = S_HI_RD;
              end else begin
                phase_next = PH_END;
              end
            end
          end
          PH_SWAP: begin
            if (scan < wc) st_next = S_SW_CHK;
            else phase_next = PH_END;
          end
          PH_END: begin
            phase_next = PH_DONE;
            res_next = '{kind: K_END, first_slot: '0, second_slot: '0, last: 1'b1};
            st_next = S_EMIT;
          end
          default: st_next = S_IDLE;
        endcase
      end
      S_EX_MAP: begin
        scan_next = scan + 1'b1;
        if (map_rd[MAP_W-1]) begin
          st_next = S_DISP;
        end else begin
          res_next = '{kind: K_COPY, first_slot: map_rd[SLOT_W-1:0],
                       second_slot: scan[SLOT_W-1:0], last: 1'b0};
          st_next = S_EMIT;
        end
      end
      S_CP_CHK: begin
        scan_next = scan + 1'b1;
        m_next = map_rd;
        cur_next = scan[SLOT_W-1:0];
        if (st_rd || rc_rd != '0) begin
          st_next = S_DISP;
        end else begin
          st_we = 1'b1;
          st_wd = 1'b1;
          total_next = total + 1'b1;
          rupd_next = rupd + 1'b1;
          if (map_rd[MAP_W-1]) begin
            res_next = '{kind: K_CLEAR, first_slot: scan[SLOT_W-1:0],
                         second_slot: '0, last: 1'b0};
            st_next = S_EMIT;
          end else if (map_rd < wc) begin
            rc_ra = map_rd[SLOT_W-1:0];
            st_next = S_CP_DEC;
          end else begin
            res_next = '{kind: K_COPY, first_slot: map_rd[SLOT_W-1:0],
                         second_slot: scan[SLOT_W-1:0], last: 1'b0};
            st_next = S_EMIT;
          end
        end
      end
      S_CP_DEC: begin
        rc_wa = m[SLOT_W-1:0];
        rc_wd = rc_rd - 1'b1;
        rc_we = (rc_rd != '0);
        res_next = '{kind: K_COPY, first_slot: m[SLOT_W-1:0], second_slot: cur, last: 1'b0};
        st_next = S_EMIT;
      end
      S_HI_RD: begin
        if (scan < wc) begin
          st_next = S_HI_WR;
        end else begin
          scan_next = '0;
          phase_next = PH_SWAP;
          st_next = S_DISP;
        end
      end
      S_HI_WR: begin
        ho_we = 1'b1;
        ho_wd = st_rd ? NO_HOLDER : scan;
        scan_next = scan + 1'b1;
        st_next = S_HI_RD;
      end
      S_SW_CHK: begin
        scan_next = scan + 1'b1;
        m_next = map_rd;
        hf_next = ho_rd;
        cur_next = scan[SLOT_W-1:0];
        p_next = scan + 1'b1;
        if (st_rd) begin
          st_next = S_DISP;
        end else if (ho_rd == map_rd) begin
          st_we = 1'b1;
          st_wd = 1'b1;
          st_next = S_DISP;
        end else begin
          st_next = S_SR_RD;
        end
      end
      S_SR_RD: begin
        ho_ra = p[SLOT_W-1:0];
        if (p < wc) begin
          st_next = S_SR_CHK;
        end else begin
          phase_next = PH_ERROR;
          res_next = '{kind: K_ERROR, first_slot: cur, second_slot: '0, last: 1'b1};
          st_next = S_EMIT;
        end
      end
      S_SR_CHK: begin
        if (ho_rd == m) begin
          ho_we = 1'b1;
          ho_wa = p[SLOT_W-1:0];
          ho_wd = hf;
          st_next = S_SW_W2;
        end else begin
          p_next = p + 1'b1;
          st_next = S_SR_RD;
        end
      end
      S_SW_W2: begin
        ho_we = 1'b1;
        ho_wa = cur;
        ho_wd = m;
        st_we = 1'b1;
        st_wa = cur;
        st_wd = 1'b1;
        res_next = '{kind: K_SWAP, first_slot: cur, second_slot: p[SLOT_W-1:0], last: 1'b0};
        st_next = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready) st_next = S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      phase <= PH_IDLE;
      scan <= '0;
      total <= '0;
      rupd <= '0;
      full <= '0;
      orig <= '0;
      wc <= '0;
    end else begin
      st <= st_next;
      phase <= phase_next;
      scan <= scan_next;
      total <= total_next;
      rupd <= rupd_next;
      full <= full_next;
      orig <= orig_next;
      wc <= wc_next;
    end
    p <= p_next;
    m <= m_next;
    hf <= hf_next;
    cur <= cur_next;
    res <= res_next;
  end

`ifndef SYNTHESIS
  a_load_only_when_stopped: assert property (@(posedge clk) disable iff (rst)
    map_we |-> loadable) else $error("map written during scheduling");
  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.last == (res.kind == K_END || res.kind == K_ERROR)))
    else $error("last flag mismatch");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan <= MAX_FRAG) else $error("scan index out of range");
  a_settled_bound: assert property (@(posedge clk) disable iff (rst)
    total <= wc) else $error("settled total exceeds working count");
`endif

endmodule
